### rtl/bht_pkg.sv
// Package with shared types and constants for the bucketed hash table.
`timescale 1ns / 1ps
package bht_pkg;
  localparam int MaxBuckets = 256;
  localparam int Ways = 8;
  localparam int MinBuckets = 13;
  localparam int Slots = MaxBuckets * Ways;
  localparam int SlotW = $clog2(Slots);
  localparam int WayW = $clog2(Ways);
  localparam int BucketW = $clog2(MaxBuckets);
  localparam int CountW = 12;
  localparam int CfgW = 9;
  localparam int KeyW = 64;
  localparam int ValW = 64;
  localparam int QDepth = 2;

  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_INSERT = 2'd1,
    OP_ERASE  = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  // One classified command: the bucket is already worked out by the front end.
  typedef struct packed {
    op_t                op;
    logic [KeyW-1:0]    key;
    logic [ValW-1:0]    value;
    logic [BucketW-1:0] bucket;
  } cmd_t;

  typedef enum logic [1:0] {
    FS_IDLE,
    FS_DIV,
    FS_PUSH
  } front_state_t;

  typedef enum logic [2:0] {
    BS_INIT,
    BS_IDLE,
    BS_CLEAR,
    BS_READ,
    BS_SCAN,
    BS_WRITE,
    BS_OUT
  } back_state_t;
endpackage

### rtl/bht_ram.sv
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
module bht_ram #(
  parameter int Width = 64,
  parameter int Depth = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

### rtl/bht_front.sv
// Front end: accepts commands and reduces the key modulo the bucket count.
`timescale 1ns / 1ps
module bht_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [bht_pkg::CfgW-1:0]     nbuckets,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  bht_pkg::op_t                 in_op,
  input  logic [bht_pkg::KeyW-1:0]     in_key,
  input  logic [bht_pkg::ValW-1:0]     in_value,
  output logic                         cmd_valid,
  input  logic                         cmd_ready,
  output bht_pkg::cmd_t                cmd
);
  // Restoring division, eight quotient bits per cycle over 64 bits.
  localparam int Step = 8;
  localparam int DivW = bht_pkg::CfgW + 1;

  bht_pkg::front_state_t state_r, state_nxt;
  logic [bht_pkg::KeyW-1:0] key_r, shift_r, shift_nxt;
  logic [bht_pkg::ValW-1:0] value_r;
  bht_pkg::op_t             op_r;
  logic [DivW-1:0]          rem_r, rem_nxt;
  logic [bht_pkg::CfgW-1:0] div_r;
  logic [3:0]               cnt_r, cnt_nxt;
  logic [bht_pkg::CfgW-1:0] eff;
  logic                     load;

  always_comb begin
    if (nbuckets < bht_pkg::CfgW'(bht_pkg::MinBuckets)) begin
      eff = bht_pkg::CfgW'(bht_pkg::MinBuckets);
    end else if (nbuckets > bht_pkg::CfgW'(bht_pkg::MaxBuckets)) begin
      eff = bht_pkg::CfgW'(bht_pkg::MaxBuckets);
    end else begin
      eff = nbuckets;
    end
  end

  always_comb begin
    logic [DivW-1:0] r;
    logic [bht_pkg::KeyW-1:0] s;
    r = rem_r;
    s = shift_r;
    for (int i = 0; i < Step; i++) begin
      r = {r[DivW-2:0], s[bht_pkg::KeyW-1]};
      s = {s[bht_pkg::KeyW-2:0], 1'b0};
      if (r >= {1'b0, div_r}) begin
        r = r - {1'b0, div_r};
      end
    end
    rem_nxt = r;
    shift_nxt = s;
  end

  always_comb begin
    state_nxt = state_r;
    in_ready = 1'b0;
    cmd_valid = 1'b0;
    load = 1'b0;
    cnt_nxt = cnt_r;
    case (state_r)
      bht_pkg::FS_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          load = 1'b1;
          cnt_nxt = '0;
          state_nxt = bht_pkg::FS_DIV;
        end
      end
      bht_pkg::FS_DIV: begin
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r == 4'(bht_pkg::KeyW / Step - 1)) begin
          state_nxt = bht_pkg::FS_PUSH;
        end
      end
      bht_pkg::FS_PUSH: begin
        cmd_valid = 1'b1;
        if (cmd_ready) begin
          state_nxt = bht_pkg::FS_IDLE;
        end
      end
      default: state_nxt = bht_pkg::FS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bht_pkg::FS_IDLE;
      cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      key_r <= in_key;
      shift_r <= in_key;
      value_r <= in_value;
      op_r <= in_op;
      rem_r <= '0;
      div_r <= eff;
    end else if (state_r == bht_pkg::FS_DIV) begin
      rem_r <= rem_nxt;
      shift_r <= shift_nxt;
    end
  end

  assign cmd.op = op_r;
  assign cmd.key = key_r;
  assign cmd.value = value_r;
  assign cmd.bucket = rem_r[bht_pkg::BucketW-1:0];
endmodule

### rtl/bht_queue.sv
// Small command queue between the front end and the back end.
`timescale 1ns / 1ps
module bht_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  output logic          push_ready,
  input  bht_pkg::cmd_t push_data,
  output logic          pop_valid,
  input  logic          pop_ready,
  output bht_pkg::cmd_t pop_data
);
  localparam int PtrW = $clog2(bht_pkg::QDepth);

  bht_pkg::cmd_t    mem_r [bht_pkg::QDepth];
  logic [PtrW-1:0]  wp_r, rp_r;
  logic [PtrW:0]    cnt_r;
  logic             push, pop;

  assign push_ready = (cnt_r != (PtrW+1)'(bht_pkg::QDepth));
  assign pop_valid = (cnt_r != '0);
  assign push = push_valid && push_ready;
  assign pop = pop_valid && pop_ready;
  assign pop_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (PtrW+1)'(push) - (PtrW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_data;
  end
endmodule

### rtl/bht_back.sv
// Back end: scans a bucket or clears all, updates the table, forms results.
`timescale 1ns / 1ps
module bht_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cmd_valid,
  output logic                        cmd_ready,
  input  bht_pkg::cmd_t               cmd,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_found,
  output logic [bht_pkg::ValW-1:0]    out_old_value,
  output logic                        out_full,
  output logic [bht_pkg::CountW-1:0]  out_count
);
  bht_pkg::back_state_t state_r, state_nxt;
  bht_pkg::cmd_t        cmd_r;
  logic [bht_pkg::CountW-1:0]  count_r;
  logic [bht_pkg::BucketW-1:0] clr_r;
  logic [bht_pkg::WayW:0]      way_r;
  logic                        hit_r, free_r;
  logic [bht_pkg::WayW-1:0]    hitw_r, freew_r;
  logic [bht_pkg::ValW-1:0]    old_r;
  logic                        found_r, full_r;

  logic                        kwe, vwe, mwe;
  logic [bht_pkg::SlotW-1:0]   addr;
  logic [bht_pkg::BucketW-1:0] maddr;
  logic [bht_pkg::Ways-1:0]    mwdata, mrd, mask_nxt;
  logic [bht_pkg::KeyW-1:0]    krd;
  logic [bht_pkg::ValW-1:0]    vrd;
  logic [bht_pkg::WayW-1:0]    scanw, prevw, wrw;
  logic [bht_pkg::SlotW-1:0]   scan_slot;
  logic                        prev_match, new_entry, drop_entry;

  bht_ram #(.Width(bht_pkg::KeyW), .Depth(bht_pkg::Slots)) u_keys (
    .clk(clk), .we(kwe), .addr(addr), .wdata(cmd_r.key), .rdata(krd));
  bht_ram #(.Width(bht_pkg::ValW), .Depth(bht_pkg::Slots)) u_vals (
    .clk(clk), .we(vwe), .addr(addr), .wdata(cmd_r.value), .rdata(vrd));
  // One word per bucket holds the valid bits of its ways.
  bht_ram #(.Width(bht_pkg::Ways), .Depth(bht_pkg::MaxBuckets)) u_masks (
    .clk(clk), .we(mwe), .addr(maddr), .wdata(mwdata), .rdata(mrd));

  assign scanw = way_r[bht_pkg::WayW-1:0];
  assign prevw = scanw - 1'b1;
  assign scan_slot = {cmd_r.bucket, scanw};
  assign wrw = hit_r ? hitw_r : freew_r;
  // The data read last cycle belongs to the previous way.
  assign prev_match = mrd[prevw] && (krd == cmd_r.key);
  assign new_entry = (cmd_r.op == bht_pkg::OP_INSERT) && !hit_r && free_r;
  assign drop_entry = (cmd_r.op == bht_pkg::OP_ERASE) && hit_r;

  always_comb begin
    mask_nxt = mrd;
    if (new_entry) mask_nxt[freew_r] = 1'b1;
    if (drop_entry) mask_nxt[hitw_r] = 1'b0;
  end

  always_comb begin
    state_nxt = state_r;
    cmd_ready = 1'b0;
    kwe = 1'b0;
    vwe = 1'b0;
    mwe = 1'b0;
    addr = scan_slot;
    maddr = cmd_r.bucket;
    mwdata = mask_nxt;
    case (state_r)
      bht_pkg::BS_INIT: begin
        mwe = 1'b1;
        maddr = clr_r;
        mwdata = '0;
        if (clr_r == '1) state_nxt = bht_pkg::BS_IDLE;
      end
      bht_pkg::BS_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) begin
          state_nxt = (cmd.op == bht_pkg::OP_CLEAR) ? bht_pkg::BS_CLEAR
                                                    : bht_pkg::BS_READ;
        end
      end
      bht_pkg::BS_CLEAR: begin
        mwe = 1'b1;
        maddr = clr_r;
        mwdata = '0;
        if (clr_r == '1) state_nxt = bht_pkg::BS_OUT;
      end
      bht_pkg::BS_READ: state_nxt = bht_pkg::BS_SCAN;
      bht_pkg::BS_SCAN: begin
        if (way_r == (bht_pkg::WayW+1)'(bht_pkg::Ways) || (prev_match && !hit_r)) begin
          state_nxt = bht_pkg::BS_WRITE;
        end
      end
      bht_pkg::BS_WRITE: begin
        addr = {cmd_r.bucket, wrw};
        if (cmd_r.op == bht_pkg::OP_INSERT && (hit_r || free_r)) begin
          vwe = 1'b1;
          kwe = !hit_r;
        end
        mwe = new_entry || drop_entry;
        state_nxt = bht_pkg::BS_OUT;
      end
      bht_pkg::BS_OUT: begin
        if (out_ready) state_nxt = bht_pkg::BS_IDLE;
      end
      default: state_nxt = bht_pkg::BS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bht_pkg::BS_INIT;
      clr_r <= '0;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == bht_pkg::BS_INIT || state_r == bht_pkg::BS_CLEAR) begin
        clr_r <= clr_r + 1'b1;
      end
      if (state_r == bht_pkg::BS_IDLE && cmd_valid && cmd.op == bht_pkg::OP_CLEAR) begin
        count_r <= '0;
      end
      if (state_r == bht_pkg::BS_WRITE) begin
        if (new_entry) begin
          count_r <= count_r + 1'b1;
        end else if (drop_entry) begin
          count_r <= count_r - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      bht_pkg::BS_IDLE: begin
        cmd_r <= cmd;
        way_r <= '0;
        hit_r <= 1'b0;
        free_r <= 1'b0;
        found_r <= 1'b0;
        full_r <= 1'b0;
        old_r <= '0;
      end
      bht_pkg::BS_READ: begin
        way_r <= way_r + 1'b1;
      end
      bht_pkg::BS_SCAN: begin
        if (!mrd[prevw] && !free_r) begin
          free_r <= 1'b1;
          freew_r <= prevw;
        end
        if (prev_match && !hit_r) begin
          hit_r <= 1'b1;
          hitw_r <= prevw;
          old_r <= vrd;
        end
        way_r <= way_r + 1'b1;
      end
      bht_pkg::BS_WRITE: begin
        found_r <= hit_r;
        full_r <= (cmd_r.op == bht_pkg::OP_INSERT) && !hit_r && !free_r;
      end
      default: ;
    endcase
  end

  assign out_valid = (state_r == bht_pkg::BS_OUT);
  assign out_found = found_r;
  assign out_old_value = old_r;
  assign out_full = full_r;
  assign out_count = count_r;
endmodule

### rtl/bucketed_hash_table.sv
// Top level of the bucketed hash table.
`timescale 1ns / 1ps
// Set-associative key/value table: 8 ways per bucket, keyed by a 64-bit hash, and
// 13 to 256 buckets (256 after reset; a written count is clamped). The front end
// takes one command and reduces the key modulo the bucket count with a restoring
// divider that retires 8 bits a cycle, then hands it on; it takes no new command
// until it has handed the last one on. The back end picks up a command, starts the
// read, scans the ways (it stops at the first matching key), writes and then holds
// the result until it is transferred. With a two-entry queue between them the two
// overlap. The valid bits of each bucket sit in a small RAM that is wiped bucket by
// bucket after reset before the first command runs, and again on every clear.
module bucketed_hash_table (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_we,
  input  logic [8:0]    cfg_wdata,
  input  logic          in_tvalid,
  output logic          in_tready,
  // opcode[1:0], key[65:2], value[129:66], zero fill
  input  logic [135:0]  in_tdata,
  output logic          out_tvalid,
  input  logic          out_tready,
  // found[0], old_value[64:1], bucket_full[65], entry_count[77:66], zero fill
  output logic [79:0]   out_tdata
);
  logic [bht_pkg::CfgW-1:0] nbuckets_r;
  logic          qi_valid, qi_ready, qo_valid, qo_ready;
  bht_pkg::cmd_t qi_data, qo_data;
  logic                           found, full;
  logic [bht_pkg::ValW-1:0]       old;
  logic [bht_pkg::CountW-1:0]     count;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nbuckets_r <= bht_pkg::CfgW'(bht_pkg::MaxBuckets);
    end else if (cfg_we) begin
      nbuckets_r <= cfg_wdata;
    end
  end

  bht_front u_front (
    .clk(clk), .rst_n(rst_n), .nbuckets(nbuckets_r),
    .in_valid(in_tvalid), .in_ready(in_tready),
    .in_op(bht_pkg::op_t'(in_tdata[1:0])), .in_key(in_tdata[65:2]),
    .in_value(in_tdata[129:66]),
    .cmd_valid(qi_valid), .cmd_ready(qi_ready), .cmd(qi_data));

  bht_queue u_queue (
    .clk(clk), .rst_n(rst_n),
    .push_valid(qi_valid), .push_ready(qi_ready), .push_data(qi_data),
    .pop_valid(qo_valid), .pop_ready(qo_ready), .pop_data(qo_data));

  bht_back u_back (
    .clk(clk), .rst_n(rst_n),
    .cmd_valid(qo_valid), .cmd_ready(qo_ready), .cmd(qo_data),
    .out_valid(out_tvalid), .out_ready(out_tready),
    .out_found(found), .out_old_value(old), .out_full(full), .out_count(count));

  assign out_tdata = {2'b00, count, full, old, found};
endmodule

### tb/tb.sv
// Self-checking testbench for the bucketed hash table.
`timescale 1ns / 1ps

class table_scoreboard;
  typedef struct {
    logic        found;
    logic [63:0] old_value;
    logic        full;
    logic [11:0] count;
  } reply_t;

  logic [63:0] keys [bht_pkg::Slots];
  logic [63:0] vals [bht_pkg::Slots];
  bit          valid [bht_pkg::Slots];
  logic [11:0] entries;
  logic [8:0]  buckets;
  reply_t      pending [$];
  int          errors;

  function void clear_state();
    foreach (valid[i]) valid[i] = 0;
    entries = 0;
    buckets = 9'd256;
    pending.delete();
    errors = 0;
  endfunction

  // Folds an accepted command into the table copy and queues its expected reply.
  function void note_command(bht_pkg::op_t op, logic [63:0] key, logic [63:0] val);
    int     n;
    int     base;
    int     hit;
    int     free_slot;
    reply_t r;
    r = '{1'b0, 64'd0, 1'b0, 12'd0};
    hit = -1;
    free_slot = -1;
    if (op == bht_pkg::OP_CLEAR) begin
      foreach (valid[i]) valid[i] = 0;
      entries = 0;
    end else begin
      n = buckets;
      if (n < bht_pkg::MinBuckets) n = bht_pkg::MinBuckets;
      if (n > bht_pkg::MaxBuckets) n = bht_pkg::MaxBuckets;
      base = int'(key % 64'(n)) * bht_pkg::Ways;
      for (int w = 0; w < bht_pkg::Ways; w++) begin
        if (valid[base + w]) begin
          if (hit < 0 && keys[base + w] == key) hit = base + w;
        end else if (free_slot < 0) begin
          free_slot = base + w;
        end
      end
      if (hit >= 0) begin
        r.found = 1'b1;
        r.old_value = vals[hit];
      end
      if (op == bht_pkg::OP_INSERT) begin
        if (hit >= 0) vals[hit] = val;
        else if (free_slot >= 0) begin
          keys[free_slot] = key;
          vals[free_slot] = val;
          valid[free_slot] = 1;
          entries = entries + 12'd1;
        end else r.full = 1'b1;
      end else if (op == bht_pkg::OP_ERASE && hit >= 0) begin
        valid[hit] = 0;
        entries = entries - 12'd1;
      end
    end
    r.count = entries;
    pending.push_back(r);
  endfunction

  function void report(string what);
    $display("mismatch: %s", what);
    errors++;
  endfunction

  function void check_reply(logic [79:0] data);
    reply_t e;
    if (pending.size() == 0) begin
      report($sformatf("unexpected reply %h", data));
      return;
    end
    e = pending.pop_front();
    if (data[0] !== e.found)
      report($sformatf("found %b, want %b", data[0], e.found));
    if (data[64:1] !== e.old_value)
      report($sformatf("old_value %h, want %h", data[64:1], e.old_value));
    if (data[65] !== e.full)
      report($sformatf("bucket_full %b, want %b", data[65], e.full));
    if (data[77:66] !== e.count)
      report($sformatf("entry_count %0d, want %0d", data[77:66], e.count));
  endfunction
endclass

module tb;
  logic         clk;
  logic         rst_n;
  logic         cfg_we;
  logic [8:0]   cfg_wdata;
  logic         in_tvalid;
  logic         in_tready;
  logic [135:0] in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  logic [79:0]  out_tdata;

  table_scoreboard board;
  bit          calm;
  int          idle_cycles;
  logic [63:0] used_keys [$];

  bucketed_hash_table dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Result side: random stalls, checks at the rising edge.
  always @(negedge clk) begin
    out_tready <= calm ? 1'b1 : ($urandom_range(99) >= 34);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) board.check_reply(out_tdata);
  end

  // Watchdog on cycles with no transfer on either side.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("FAIL");
      $finish;
    end
  end

  // Starts and ends at a falling edge; valid stays up after the transfer until
  // the next idle cycle or the next item replaces the data.
  task automatic send(bht_pkg::op_t op, logic [63:0] key, logic [63:0] val);
    while (!calm && $urandom_range(99) < 34) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {6'd0, val, key, op};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    board.note_command(op, key, val);
    @(negedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (board.pending.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic write_buckets(logic [8:0] n);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= n;
    @(negedge clk);
    cfg_we <= 1'b0;
    board.buckets = n;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Often reuses keys seen before, else often fills bucket 0 of 13 or 256 buckets.
  function automatic logic [63:0] pick_key();
    int r;
    r = $urandom_range(99);
    if (r < 45 && used_keys.size() > 0)
      return used_keys[$urandom_range(used_keys.size() - 1)];
    if (r < 75)
      return 64'($urandom_range(15)) * 64'd13 * 64'd256 * 64'($urandom_range(3) + 1);
    return rand64();
  endfunction

  task automatic random_phase(int count);
    int           r;
    logic [63:0]  k;
    bht_pkg::op_t op;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      k = pick_key();
      if (used_keys.size() < 200) used_keys.push_back(k);
      if (r < 45) op = bht_pkg::OP_INSERT;
      else if (r < 70) op = bht_pkg::OP_LOOKUP;
      else if (r < 98) op = bht_pkg::OP_ERASE;
      else op = bht_pkg::OP_CLEAR;
      send(op, k, rand64());
    end
  endtask

  initial begin
    board = new();
    board.clear_state();
    calm = 1'b0;
    idle_cycles = 0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: extremes, each operation, absent keys, a full bucket, clear.
    send(bht_pkg::OP_LOOKUP, 64'd0, 64'd0);
    send(bht_pkg::OP_INSERT, 64'd0, '1);
    send(bht_pkg::OP_INSERT, '1, 64'h5555_5555_5555_5555);
    send(bht_pkg::OP_INSERT, 64'd0, 64'hAAAA_AAAA_AAAA_AAAA);
    send(bht_pkg::OP_LOOKUP, '1, 64'd0);
    send(bht_pkg::OP_ERASE, 64'd7, '1);
    for (int i = 1; i <= 8; i++) send(bht_pkg::OP_INSERT, 64'(i * 256), 64'(i));
    send(bht_pkg::OP_LOOKUP, 64'd2048, 64'd0);
    send(bht_pkg::OP_ERASE, '1, 64'd0);
    send(bht_pkg::OP_ERASE, 64'd0, 64'd0);
    send(bht_pkg::OP_INSERT, 64'd0, 64'd1);
    send(bht_pkg::OP_CLEAR, '1, '1);
    send(bht_pkg::OP_LOOKUP, 64'd256, 64'd0);

    // Register extremes, with entries left in place across changes.
    write_buckets(9'd0);
    random_phase(150);
    write_buckets(9'd13);
    random_phase(200);
    write_buckets(9'h1FF);
    random_phase(200);
    write_buckets(9'd100);
    calm = 1'b1;
    random_phase(300);
    calm = 1'b0;
    write_buckets(9'd256);
    random_phase(300);
    write_buckets(9'd12);
    random_phase(300);
    write_buckets(9'd257);
    random_phase(280);

    drain();
    if (board.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

### files.f
rtl/bht_pkg.sv
rtl/bht_ram.sv
rtl/bht_front.sv
rtl/bht_queue.sv
rtl/bht_back.sv
rtl/bucketed_hash_table.sv
tb/tb.sv
